FILE: hdl/rcss_pkg.sv
package rcss_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SCAN   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [1:0] CFG_IDLE_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_KEY_PERIOD    = 2'd1;
  localparam logic [1:0] CFG_REPEAT_TARGET = 2'd2;
  localparam int         CFG_DATA_W        = 10;

  localparam logic [9:0] IDLE_PERIOD_RST   = 10'd50;
  localparam logic [9:0] KEY_PERIOD_RST    = 10'd5;
  localparam logic [7:0] REPEAT_TARGET_RST = 8'd10;

  localparam logic [3:0] KEY_NONE  = 4'd0;
  localparam logic [3:0] KEY_MODE  = 4'd9;
  localparam logic [3:0] KEY_START = 4'd10;

  localparam logic [11:0] ADC_CENTRE  = 12'd2048;
  localparam int          AXIS_GAIN   = 101;
  localparam int          AXIS_SPAN   = 2049;
  localparam logic [6:0]  AXIS_LIMIT  = 7'd100;
  localparam int          RECIP_SHIFT = 24;
  localparam int          RECIP_W     = 22;

  localparam logic [3:0] LEVEL3_MIN = 4'd9;
  localparam logic [3:0] LEVEL2_MIN = 4'd5;
  localparam logic [3:0] LEVEL1_MIN = 4'd1;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_SCAN,
    KIND_REPORT,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  key_code;
    logic [11:0] adc_left_horizontal;
    logic [11:0] adc_left_vertical;
    logic [11:0] adc_right_horizontal;
    logic [11:0] adc_right_vertical;
    logic        sent_ok;
  } in_item_t;

  typedef struct packed {
    logic              send_request;
    logic              running;
    logic              mode_out;
    logic signed [7:0] left_horizontal;
    logic signed [7:0] left_vertical;
    logic signed [7:0] right_horizontal;
    logic signed [7:0] right_vertical;
    logic [3:0]        pending_key_out;
    logic [7:0]        key_sequence_out;
    logic [3:0]        hit_count;
    logic [1:0]        signal_level;
  } out_item_t;

  typedef struct packed {
    kind_t           kind;
    logic [3:0]      key;
    logic            sent_ok;
    logic [3:0][6:0] axis_mag;
    logic [3:0]      axis_neg;
  } cmd_t;

endpackage

FILE: hdl/remote_control_send_scheduler.sv
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     rcss_pkg::in_item_t
// out_      output     out_valid / out_ready   rcss_pkg::out_item_t
// cfg_      input      cfg_we                  cfg_index, cfg_data
//
// One request is taken per cycle while in_ready is high.
// The stages are the classifying front register with the axis reciprocal multiply,
// a four-entry queue, and the state update in the back end feeding the output register.
// Reset is synchronous, active low; it restores register defaults, clears control state.
// A stalled output holds the back end; the output register, the queue and the front
// register then hold up to six requests before in_ready falls.
module remote_control_send_scheduler #(
  parameter int DEAD_ZONE     = 100,
  parameter int WINDOW_LENGTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rcss_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rcss_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [rcss_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           push_valid;
  logic           push_ready;
  rcss_pkg::cmd_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  rcss_pkg::cmd_t pop_data;

  rcss_front #(
    .DEAD_ZONE (DEAD_ZONE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rcss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rcss_back #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/rcss_front.sv
module rcss_front #(
  parameter int DEAD_ZONE = 100
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rcss_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output rcss_pkg::cmd_t    push_data
);

  localparam int Span = rcss_pkg::AXIS_SPAN - DEAD_ZONE;
  localparam longint unsigned RecipFull =
    ((longint'(rcss_pkg::AXIS_GAIN) << rcss_pkg::RECIP_SHIFT) + longint'(Span) - 1) / Span;
  localparam logic [rcss_pkg::RECIP_W-1:0] Recip = rcss_pkg::RECIP_W'(RecipFull);
  localparam logic [11:0] DeadZone = 12'(DEAD_ZONE);
  localparam int ProdW = 12 + rcss_pkg::RECIP_W;

  logic [3:0][11:0] adc;
  logic [3:0][11:0] mag_dz;
  logic [3:0]       neg;
  rcss_pkg::kind_t  kind;

  logic             s1_valid_r;
  rcss_pkg::kind_t  s1_kind_r;
  logic [3:0]       s1_key_r;
  logic             s1_ok_r;
  logic [3:0][11:0] s1_mag_r;
  logic [3:0]       s1_neg_r;

  logic [3:0][ProdW-1:0] prod;
  logic [3:0][9:0]       quot;
  logic [3:0][6:0]       quot_sat;

  assign adc[0] = in_data.adc_left_horizontal;
  assign adc[1] = in_data.adc_left_vertical;
  assign adc[2] = in_data.adc_right_horizontal;
  assign adc[3] = in_data.adc_right_vertical;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [11:0] mag;
      neg[i] = ~adc[i][11];
      mag = adc[i][11] ? {1'b0, adc[i][10:0]} : (rcss_pkg::ADC_CENTRE - adc[i]);
      mag_dz[i] = (mag > DeadZone) ? (mag - DeadZone) : 12'd0;
    end
  end

  always_comb begin
    case (in_data.operation)
      rcss_pkg::OP_TICK:   kind = rcss_pkg::KIND_TICK;
      rcss_pkg::OP_SCAN:   kind = rcss_pkg::KIND_SCAN;
      rcss_pkg::OP_REPORT: kind = rcss_pkg::KIND_REPORT;
      default:             kind = rcss_pkg::KIND_NONE;
    endcase
  end

  assign in_ready = ~s1_valid_r | push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_kind_r <= kind;
      s1_key_r  <= in_data.key_code;
      s1_ok_r   <= in_data.sent_ok;
      s1_mag_r  <= mag_dz;
      s1_neg_r  <= neg;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = ProdW'(s1_mag_r[i]) * ProdW'(Recip);
      quot[i] = prod[i][rcss_pkg::RECIP_SHIFT +: 10];
      quot_sat[i] = (quot[i] > 10'(rcss_pkg::AXIS_LIMIT)) ? rcss_pkg::AXIS_LIMIT : quot[i][6:0];
    end
  end

  assign push_valid          = s1_valid_r;
  assign push_data.kind      = s1_kind_r;
  assign push_data.key       = s1_key_r;
  assign push_data.sent_ok   = s1_ok_r;
  assign push_data.axis_mag  = quot_sat;
  assign push_data.axis_neg  = s1_neg_r;

endmodule

FILE: hdl/rcss_queue.sv
module rcss_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rcss_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rcss_pkg::cmd_t pop_data
);

  localparam int PtrW = $clog2(rcss_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(rcss_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rcss_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(rcss_pkg::QUEUE_DEPTH);

  rcss_pkg::cmd_t  entry_r [rcss_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != Full);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Full)
    else $error("Request queue holds more entries than its depth.");
`endif

endmodule

FILE: hdl/rcss_back.sv
module rcss_back #(
  parameter int WINDOW_LENGTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [rcss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  rcss_pkg::cmd_t                  cmd,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rcss_pkg::out_item_t             out_data
);

  logic [9:0] idle_period_r;
  logic [9:0] key_period_r;
  logic [7:0] repeat_target_r;

  logic                     started_r, started_nxt;
  logic                     mode_r, mode_nxt;
  logic [9:0]               tick_r, tick_nxt;
  logic                     due_r, due_nxt;
  logic [3:0]               pending_r, pending_nxt;
  logic [7:0]               seq_r, seq_nxt;
  logic [7:0]               repeats_r, repeats_nxt;
  logic [3:0][7:0]          axis_r, axis_nxt;
  logic [WINDOW_LENGTH-1:0] ring_r, ring_nxt;
  logic [3:0]               hits_r, hits_nxt;
  logic                     send_nxt;
  logic [1:0]               level_nxt;

  logic                     out_valid_r;
  rcss_pkg::out_item_t      out_data_r, out_data_nxt;

  logic                     take;
  logic [9:0]               period;
  logic [9:0]               tick_inc;
  logic [7:0]               seq_inc;
  logic [7:0]               repeats_dec;
  logic [WINDOW_LENGTH:0]   ring_ext;

  assign cmd_ready = ~out_valid_r | out_ready;
  assign take      = cmd_valid & cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_period_r   <= rcss_pkg::IDLE_PERIOD_RST;
      key_period_r    <= rcss_pkg::KEY_PERIOD_RST;
      repeat_target_r <= rcss_pkg::REPEAT_TARGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rcss_pkg::CFG_IDLE_PERIOD:   idle_period_r   <= cfg_data;
        rcss_pkg::CFG_KEY_PERIOD:    key_period_r    <= cfg_data;
        rcss_pkg::CFG_REPEAT_TARGET: repeat_target_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign period      = (pending_r != rcss_pkg::KEY_NONE) ? key_period_r : idle_period_r;
  assign tick_inc    = tick_r + 10'd1;
  assign seq_inc     = (seq_r == 8'hFF) ? 8'd1 : seq_r + 8'd1;
  assign repeats_dec = (repeats_r != 8'd0) ? repeats_r - 8'd1 : 8'd0;
  assign ring_ext    = {ring_r, cmd.sent_ok};

  always_comb begin
    started_nxt = started_r;
    mode_nxt    = mode_r;
    tick_nxt    = tick_r;
    due_nxt     = due_r;
    pending_nxt = pending_r;
    seq_nxt     = seq_r;
    repeats_nxt = repeats_r;
    axis_nxt    = axis_r;
    ring_nxt    = ring_r;
    hits_nxt    = hits_r;
    send_nxt    = 1'b0;
    case (cmd.kind)
      rcss_pkg::KIND_TICK: begin
        if (tick_inc >= period) begin
          tick_nxt = 10'd0;
          due_nxt  = 1'b1;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      rcss_pkg::KIND_SCAN: begin
        if (!started_r) begin
          started_nxt = (cmd.key == rcss_pkg::KEY_START);
        end else begin
          for (int i = 0; i < 4; i++) begin
            logic [7:0] m8;
            m8 = {1'b0, cmd.axis_mag[i]};
            axis_nxt[i] = cmd.axis_neg[i] ? (~m8 + 8'd1) : m8;
          end
          if (cmd.key != rcss_pkg::KEY_NONE) begin
            pending_nxt = cmd.key;
            seq_nxt     = seq_inc;
            repeats_nxt = repeat_target_r;
          end
          if (cmd.key == rcss_pkg::KEY_MODE) begin
            mode_nxt = ~mode_r;
          end
          send_nxt = due_r | (cmd.key != rcss_pkg::KEY_NONE);
          due_nxt  = 1'b0;
        end
      end
      rcss_pkg::KIND_REPORT: begin
        if (cmd.sent_ok) begin
          repeats_nxt = repeats_dec;
          if (repeats_dec == 8'd0) begin
            pending_nxt = rcss_pkg::KEY_NONE;
          end
        end
        ring_nxt = ring_ext[WINDOW_LENGTH-1:0];
        hits_nxt = hits_r + {3'd0, cmd.sent_ok} - {3'd0, ring_r[WINDOW_LENGTH-1]};
      end
      default: ;
    endcase

    if (hits_nxt >= rcss_pkg::LEVEL3_MIN) begin
      level_nxt = 2'd3;
    end else if (hits_nxt >= rcss_pkg::LEVEL2_MIN) begin
      level_nxt = 2'd2;
    end else if (hits_nxt >= rcss_pkg::LEVEL1_MIN) begin
      level_nxt = 2'd1;
    end else begin
      level_nxt = 2'd0;
    end

    out_data_nxt.send_request     = send_nxt;
    out_data_nxt.running          = started_nxt;
    out_data_nxt.mode_out         = mode_nxt;
    out_data_nxt.left_horizontal  = $signed(axis_nxt[0]);
    out_data_nxt.left_vertical    = $signed(axis_nxt[1]);
    out_data_nxt.right_horizontal = $signed(axis_nxt[2]);
    out_data_nxt.right_vertical   = $signed(axis_nxt[3]);
    out_data_nxt.pending_key_out  = pending_nxt;
    out_data_nxt.key_sequence_out = seq_nxt;
    out_data_nxt.hit_count        = hits_nxt;
    out_data_nxt.signal_level     = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      mode_r      <= 1'b0;
      tick_r      <= '0;
      due_r       <= 1'b0;
      pending_r   <= rcss_pkg::KEY_NONE;
      seq_r       <= '0;
      repeats_r   <= '0;
      axis_r      <= '0;
      ring_r      <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        started_r <= started_nxt;
        mode_r    <= mode_nxt;
        tick_r    <= tick_nxt;
        due_r     <= due_nxt;
        pending_r <= pending_nxt;
        seq_r     <= seq_nxt;
        repeats_r <= repeats_nxt;
        axis_r    <= axis_nxt;
        ring_r    <= ring_nxt;
        hits_r    <= hits_nxt;
      end
      if (cmd_ready) begin
        out_valid_r <= cmd_valid;
      end
    end
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != rcss_pkg::KEY_NONE |-> seq_r != 8'd0)
    else $error("A key is pending with a zero sequence number.");
`endif

`ifndef SYNTHESIS
  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("The running flag fell without a reset.");
`endif

`ifndef SYNTHESIS
  a_hits_match: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r == 4'($countones(ring_r)))
    else $error("Success count disagrees with the outcome window.");
`endif

`ifndef SYNTHESIS
  a_send_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.send_request |-> out_data_r.running)
    else $error("A send was requested before the start key.");
`endif

endmodule
